// ===== sv/polygon_area_centroid_macros.svh =====
// Assertion macros shared by the polygon area and centroid block.
`ifndef POLYGON_AREA_CENTROID_MACROS_SVH
`define POLYGON_AREA_CENTROID_MACROS_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("polygon_area_centroid: check failed");

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("polygon_area_centroid: check failed");

`endif

// ===== sv/pac_pkg.sv =====
// Shared widths, constants and types of the polygon area and centroid block.
package pac_pkg;

  localparam int unsigned COORD_W   = 16;  // port width of a coordinate
  localparam int unsigned SUM_W     = 17;  // sum of two coordinates
  localparam int unsigned CROSS_W   = 33;  // one cross product term
  localparam int unsigned PROD_W    = 50;  // shared multiplier result
  localparam int unsigned CS_W      = 45;  // cross sum accumulator
  localparam int unsigned AREA_W    = 44;  // reported doubled area
  localparam int unsigned MOM_W     = 62;  // moment accumulators
  localparam int unsigned D3_W      = 47;  // three times the cross sum
  localparam int unsigned DVD_W     = MOM_W;
  localparam int unsigned DVS_W     = D3_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);
  localparam int unsigned MIN_VERTS = 3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/pac_vert_if.sv =====
// Vertex input channel: valid/ready handshake with one polygon vertex per beat.
interface pac_vert_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pac_pkg::COORD_W-1:0]    vert_x;
  logic signed [pac_pkg::COORD_W-1:0]    vert_y;
  logic signed [pac_pkg::COORD_W-1:0]    vert_z;
  logic                                  last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

// ===== sv/pac_res_if.sv =====
// Result output channel: valid/ready handshake with one polygon result per beat.
interface pac_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pac_pkg::AREA_W-1:0]     double_area;
  logic signed [pac_pkg::COORD_W-1:0]    center_x;
  logic signed [pac_pkg::COORD_W-1:0]    center_y;
  logic signed [pac_pkg::COORD_W-1:0]    center_z;
  logic                                  result_valid;
  logic                                  too_many;

  modport source (output valid, double_area, center_x, center_y, center_z, result_valid,
                  too_many, input ready);
  modport sink   (input valid, double_area, center_x, center_y, center_z, result_valid,
                  too_many, output ready);
endinterface

// ===== sv/pac_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module pac_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pac_pkg::DVD_W-1:0]    dividend_i,
  input  logic [pac_pkg::DVS_W-1:0]    divisor_i,
  output logic [pac_pkg::DVD_W-1:0]    quotient_o,
  output pac_pkg::div_stat_t           stat_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [pac_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [pac_pkg::DVS_W-1:0]        rem_q;
  logic [pac_pkg::DVS_W-1:0]        dvs_q;
  logic [pac_pkg::DVD_W-1:0]        quo_q;
  logic [pac_pkg::DVS_W:0]          shifted;
  logic [pac_pkg::DVS_W+1:0]        diff;
  logic                             take;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, quo_q[pac_pkg::DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign take    = ~diff[pac_pkg::DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pac_pkg::DIV_CNT_W'(pac_pkg::DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[pac_pkg::DVS_W-1:0] : shifted[pac_pkg::DVS_W-1:0];
      quo_q <= {quo_q[pac_pkg::DVD_W-2:0], take};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== sv/polygon_area_centroid.sv =====
// Top level of the shoelace polygon area and centroid block.
// An inner vertex passes ST_IDLE, ST_M2, ST_M3 and ST_M4 on one shared 17x33 multiplier.
// A vertex marked last then runs ST_FIN0 and ST_FIN1, for a valid polygon two 62-step
// divisions (x, then y), and ST_OUT, which waits while the output register is full.
// Only one vertex is in work at a time; results at most one per polygon.
// Reset (rst_ni low, asynchronous) clears the sequencer and all accumulators.
`include "polygon_area_centroid_macros.svh"

module polygon_area_centroid #(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pac_vert_if.sink    vert_i,
  pac_res_if.source   res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SH    = pac_pkg::COORD_W - COORD_BITS;

  // Saturation limits of the centroid in the coordinate range.
  localparam logic [pac_pkg::DVD_W-1:0] CMAX_MAG =
    pac_pkg::DVD_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic [pac_pkg::DVD_W-1:0] CMIN_MAG = CMAX_MAG + pac_pkg::DVD_W'(1);
  localparam logic [pac_pkg::COORD_W-1:0] CMAX16 = pac_pkg::COORD_W'(CMAX_MAG);
  localparam logic [pac_pkg::COORD_W-1:0] CMIN16 = ~CMAX16;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;   // take a vertex, first cross product
  localparam logic [3:0] ST_M2   = 4'd1;   // second cross product, form the term
  localparam logic [3:0] ST_M3   = 4'd2;   // x moment product, update cross sum
  localparam logic [3:0] ST_M4   = 4'd3;   // y moment product, update x moment
  localparam logic [3:0] ST_FIN0 = 4'd4;   // last y moment update, three times cross sum
  localparam logic [3:0] ST_FIN1 = 4'd5;   // validity, magnitudes and signs
  localparam logic [3:0] ST_SX   = 4'd6;   // start x division
  localparam logic [3:0] ST_DIVX = 4'd7;   // wait for x quotient
  localparam logic [3:0] ST_SY   = 4'd8;   // start y division
  localparam logic [3:0] ST_DIVY = 4'd9;   // wait for y quotient
  localparam logic [3:0] ST_OUT  = 4'd10;  // hand the result to the output register

  // Control and accumulator state (reset).
  logic [3:0]                    state_q, state_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic [pac_pkg::COORD_W-1:0]   prev_x_q, prev_x_d;
  logic [pac_pkg::COORD_W-1:0]   prev_y_q, prev_y_d;
  logic [pac_pkg::COORD_W-1:0]   first_z_q, first_z_d;
  logic [pac_pkg::CS_W-1:0]      cs_q, cs_d;
  logic [pac_pkg::MOM_W-1:0]     mx_q, mx_d;
  logic [pac_pkg::MOM_W-1:0]     my_q, my_d;

  // Working registers (no reset).
  logic [pac_pkg::COORD_W-1:0]   x_q, x_d;
  logic [pac_pkg::COORD_W-1:0]   y_q, y_d;
  logic                          last_q, last_d;
  logic [pac_pkg::SUM_W-1:0]     sx_q, sx_d;
  logic [pac_pkg::SUM_W-1:0]     sy_q, sy_d;
  logic [pac_pkg::CROSS_W-1:0]   a_q, a_d;
  logic [pac_pkg::PROD_W-1:0]    p_q, p_d;
  logic [pac_pkg::D3_W-1:0]      d3_q, d3_d;
  logic [pac_pkg::DVS_W-1:0]     dmag_q, dmag_d;
  logic [pac_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic                          qneg_q, qneg_d;
  logic                          valid_q, valid_d;
  logic [pac_pkg::COORD_W-1:0]   cx_q, cx_d;
  logic [pac_pkg::COORD_W-1:0]   cy_q, cy_d;

  // Output register.
  logic [pac_pkg::AREA_W-1:0]    o_area_q, o_area_d;
  logic [pac_pkg::COORD_W-1:0]   o_cx_q, o_cx_d;
  logic [pac_pkg::COORD_W-1:0]   o_cy_q, o_cy_d;
  logic [pac_pkg::COORD_W-1:0]   o_cz_q, o_cz_d;
  logic                          o_rv_q, o_rv_d;
  logic                          o_tm_q, o_tm_d;

  // Input coordinates sign-extended from their low COORD_BITS bits.
  logic [pac_pkg::COORD_W-1:0]   x_sh, y_sh;
  logic signed [pac_pkg::COORD_W-1:0] x_in, y_in;
  logic                          in_acc;
  logic                          out_free;

  // Shared multiplier.
  logic signed [pac_pkg::SUM_W-1:0]   mul_a;
  logic signed [pac_pkg::CROSS_W-1:0] mul_b;
  logic signed [pac_pkg::PROD_W-1:0]  prod;

  // Divider.
  logic                          div_start;
  logic [pac_pkg::DVD_W-1:0]     div_quo;
  pac_pkg::div_stat_t            div_stat;

  assign x_sh = vert_i.vert_x << SH;
  assign y_sh = vert_i.vert_y << SH;
  assign x_in = $signed(x_sh) >>> SH;
  assign y_in = $signed(y_sh) >>> SH;

  // The block takes a vertex only when the sequencer is idle. A finished
  // result may still be waiting in the output register at that time.
  assign vert_i.ready = (state_q == ST_IDLE);
  assign in_acc       = vert_i.valid && vert_i.ready;
  assign out_free     = !out_valid_q || res_o.ready;

  // Clamp an unsigned quotient magnitude with its sign to the coordinate range.
  function automatic logic [pac_pkg::COORD_W-1:0] sat_coord(
    input logic [pac_pkg::DVD_W-1:0] mag,
    input logic                      neg
  );
    logic [pac_pkg::COORD_W-1:0] r;
    if (!neg) begin
      r = (mag > CMAX_MAG) ? CMAX16 : mag[pac_pkg::COORD_W-1:0];
    end else begin
      r = (mag > CMIN_MAG) ? CMIN16 : pac_pkg::COORD_W'(0) - mag[pac_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // Operand selection of the shared multiplier. Each vertex after the first
  // runs four products in turn: prev_x*y, x*prev_y, (prev_x+x)*a and
  // (prev_y+y)*a, where a is the cross term of the edge.
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        mul_a = {prev_x_q[pac_pkg::COORD_W-1], prev_x_q};
        mul_b = {{(pac_pkg::CROSS_W - pac_pkg::COORD_W){y_in[pac_pkg::COORD_W-1]}}, y_in};
      end
      ST_M2: begin
        mul_a = {x_q[pac_pkg::COORD_W-1], x_q};
        mul_b = {{(pac_pkg::CROSS_W - pac_pkg::COORD_W){prev_y_q[pac_pkg::COORD_W-1]}},
                 prev_y_q};
      end
      ST_M3: begin
        mul_a = sx_q;
        mul_b = a_q;
      end
      default: begin
        mul_a = sy_q;
        mul_b = a_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign div_start = (state_q == ST_SX) || (state_q == ST_SY);

  pac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (dmag_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    first_z_d   = first_z_q;
    cs_d        = cs_q;
    mx_d        = mx_q;
    my_d        = my_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    a_d         = a_q;
    p_d         = p_q;
    d3_d        = d3_q;
    dmag_d      = dmag_q;
    dvd_d       = dvd_q;
    qneg_d      = qneg_q;
    valid_d     = valid_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    o_area_d    = o_area_q;
    o_cx_d      = o_cx_q;
    o_cy_d      = o_cy_q;
    o_cz_d      = o_cz_q;
    o_rv_d      = o_rv_q;
    o_tm_d      = o_tm_q;

    // The output register empties when its beat is taken.
    out_valid_d = out_valid_q && !res_o.ready;

    // The y moment product of the previous vertex is folded in while the
    // sequencer idles or winds up, so the multiplier never waits for it.
    if (pend_q && (state_q == ST_IDLE || state_q == ST_FIN0)) begin
      my_d   = my_q + {{(pac_pkg::MOM_W - pac_pkg::PROD_W){p_q[pac_pkg::PROD_W-1]}}, p_q};
      pend_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d    = x_in;
          y_d    = y_in;
          last_d = vert_i.last_vertex;
          if (count_q >= CNT_W'(MAX_VERTICES)) begin
            // Vertices past the limit are dropped but still may close the polygon.
            ovf_d   = 1'b1;
            state_d = vert_i.last_vertex ? ST_FIN0 : ST_IDLE;
          end else if (count_q == '0) begin
            // The first vertex only seeds the edge chain and the reported z.
            first_z_d = vert_i.vert_z;
            prev_x_d  = x_in;
            prev_y_d  = y_in;
            count_d   = CNT_W'(1);
            state_d   = vert_i.last_vertex ? ST_FIN0 : ST_IDLE;
          end else begin
            p_d     = prod;
            sx_d    = {prev_x_q[pac_pkg::COORD_W-1], prev_x_q} +
                      {x_in[pac_pkg::COORD_W-1], x_in};
            sy_d    = {prev_y_q[pac_pkg::COORD_W-1], prev_y_q} +
                      {y_in[pac_pkg::COORD_W-1], y_in};
            state_d = ST_M2;
          end
        end
      end
      ST_M2: begin
        a_d     = p_q[pac_pkg::CROSS_W-1:0] - prod[pac_pkg::CROSS_W-1:0];
        state_d = ST_M3;
      end
      ST_M3: begin
        cs_d    = cs_q + {{(pac_pkg::CS_W - pac_pkg::CROSS_W){a_q[pac_pkg::CROSS_W-1]}}, a_q};
        p_d     = prod;
        state_d = ST_M4;
      end
      ST_M4: begin
        mx_d     = mx_q + {{(pac_pkg::MOM_W - pac_pkg::PROD_W){p_q[pac_pkg::PROD_W-1]}}, p_q};
        p_d      = prod;
        pend_d   = 1'b1;
        prev_x_d = x_q;
        prev_y_d = y_q;
        count_d  = count_q + CNT_W'(1);
        state_d  = last_q ? ST_FIN0 : ST_IDLE;
      end
      ST_FIN0: begin
        // Three times the cross sum as 2*cs + cs.
        d3_d    = {{2{cs_q[pac_pkg::CS_W-1]}}, cs_q} + {cs_q[pac_pkg::CS_W-1], cs_q, 1'b0};
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        valid_d = (count_q >= CNT_W'(pac_pkg::MIN_VERTS)) && (cs_q != '0);
        dmag_d  = d3_q[pac_pkg::D3_W-1] ? (pac_pkg::DVS_W'(0) - d3_q) : d3_q;
        dvd_d   = mx_q[pac_pkg::MOM_W-1] ? (pac_pkg::DVD_W'(0) - mx_q) : mx_q;
        qneg_d  = mx_q[pac_pkg::MOM_W-1] ^ d3_q[pac_pkg::D3_W-1];
        state_d = ((count_q >= CNT_W'(pac_pkg::MIN_VERTS)) && (cs_q != '0)) ? ST_SX : ST_OUT;
      end
      ST_SX: begin
        state_d = ST_DIVX;
      end
      ST_DIVX: begin
        if (div_stat.done) begin
          cx_d    = sat_coord(div_quo, qneg_q);
          dvd_d   = my_q[pac_pkg::MOM_W-1] ? (pac_pkg::DVD_W'(0) - my_q) : my_q;
          qneg_d  = my_q[pac_pkg::MOM_W-1] ^ d3_q[pac_pkg::D3_W-1];
          state_d = ST_SY;
        end
      end
      ST_SY: begin
        state_d = ST_DIVY;
      end
      ST_DIVY: begin
        if (div_stat.done) begin
          cy_d    = sat_coord(div_quo, qneg_q);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (valid_q) begin
            // Saturate the 45-bit cross sum into the 44-bit area field.
            if (cs_q[pac_pkg::CS_W-1] != cs_q[pac_pkg::CS_W-2]) begin
              o_area_d = {cs_q[pac_pkg::CS_W-1], {(pac_pkg::AREA_W-1){~cs_q[pac_pkg::CS_W-1]}}};
            end else begin
              o_area_d = cs_q[pac_pkg::AREA_W-1:0];
            end
            o_cx_d = cx_q;
            o_cy_d = cy_q;
            o_cz_d = first_z_q;
          end else begin
            o_area_d = '0;
            o_cx_d   = '0;
            o_cy_d   = '0;
            o_cz_d   = '0;
          end
          o_rv_d      = valid_q;
          o_tm_d      = ovf_q;
          out_valid_d = 1'b1;
          // Start the next polygon from a clean slate.
          count_d     = '0;
          ovf_d       = 1'b0;
          prev_x_d    = '0;
          prev_y_d    = '0;
          first_z_d   = '0;
          cs_d        = '0;
          mx_d        = '0;
          my_d        = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      first_z_q   <= '0;
      cs_q        <= '0;
      mx_q        <= '0;
      my_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      first_z_q   <= first_z_d;
      cs_q        <= cs_d;
      mx_q        <= mx_d;
      my_q        <= my_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    last_q   <= last_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    a_q      <= a_d;
    p_q      <= p_d;
    d3_q     <= d3_d;
    dmag_q   <= dmag_d;
    dvd_q    <= dvd_d;
    qneg_q   <= qneg_d;
    valid_q  <= valid_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    o_area_q <= o_area_d;
    o_cx_q   <= o_cx_d;
    o_cy_q   <= o_cy_d;
    o_cz_q   <= o_cz_d;
    o_rv_q   <= o_rv_d;
    o_tm_q   <= o_tm_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.double_area  = o_area_q;
  assign res_o.center_x     = o_cx_q;
  assign res_o.center_y     = o_cy_q;
  assign res_o.center_z     = o_cz_q;
  assign res_o.result_valid = o_rv_q;
  assign res_o.too_many     = o_tm_q;

  // The divider only runs while the sequencer waits on it.
  `PAC_ASSERT_IMP(a_div_busy_state, div_stat.busy, state_q == ST_DIVX || state_q == ST_DIVY)
  // An invalid polygon reports all-zero values.
  `PAC_ASSERT_IMP(a_invalid_zero, out_valid_q && !o_rv_q,
                  o_area_q == '0 && o_cx_q == '0 && o_cy_q == '0 && o_cz_q == '0)
  // The accepted vertex count never passes the limit.
  `PAC_ASSERT_IMP(a_count_limit, 1'b1, count_q <= CNT_W'(MAX_VERTICES))
  // Handing off a result leaves the accumulators cleared for the next polygon.
  `PAC_ASSERT_NXT(a_clear_after_out, state_q == ST_OUT && out_free,
                  count_q == '0 && cs_q == '0 && !ovf_q)

endmodule
